FILE: rtl/mtg_pkg.sv
package mtg_pkg;

  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned TWIST_OFFSET = 397;
  localparam int unsigned IDX_W        = 10;
  localparam int unsigned WORD_W       = 32;

  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0] FAR_LIMIT  = IDX_W'(STATE_WORDS - TWIST_OFFSET);
  localparam logic [IDX_W-1:0] FAR_OFFSET = IDX_W'(TWIST_OFFSET);

  localparam logic [WORD_W-1:0] TWIST_MAGIC  = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0] SEED_MULT    = 32'd69069;
  localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd4357;
  localparam logic [WORD_W-1:0] UPPER_MASK   = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOWER_MASK   = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hEFC6_0000;

  // Input item codes
  localparam logic FUNC_DRAW = 1'b0;
  localparam logic FUNC_SEED = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_PRIME,
    ST_REGEN_RD,
    ST_REGEN_WR,
    ST_FETCH,
    ST_DATA
  } state_t;

  // Store access request from the sequencer
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [WORD_W-1:0] wdata;
    logic              re0;
    logic [IDX_W-1:0]  raddr0;
    logic              re1;
    logic [IDX_W-1:0]  raddr1;
  } store_req_t;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] y_in);
    logic [WORD_W-1:0] y;
    y = y_in;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    return y ^ (y >> 18);
  endfunction

  function automatic logic [WORD_W-1:0] twist(input logic [WORD_W-1:0] cur,
                                              input logic [WORD_W-1:0] nxt,
                                              input logic [WORD_W-1:0] far);
    logic [WORD_W-1:0] mix;
    mix = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
    return far ^ (mix >> 1) ^ (nxt[0] ? TWIST_MAGIC : '0);
  endfunction

endpackage

FILE: rtl/mtg_in_if.sv
interface mtg_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] seed_value;

  modport source(output valid, output func, output seed_value, input ready);
  modport sink(input valid, input func, input seed_value, output ready);
endinterface

FILE: rtl/mtg_out_if.sv
interface mtg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source(output valid, output random_word, input ready);
  modport sink(input valid, input random_word, output ready);
endinterface

FILE: rtl/mtg_store.sv
module mtg_store (
  input  logic                        clk,
  input  mtg_pkg::store_req_t         req,
  output logic [mtg_pkg::WORD_W-1:0]  rd0,
  output logic [mtg_pkg::WORD_W-1:0]  rd1
);

  logic [mtg_pkg::WORD_W-1:0] mem [mtg_pkg::STATE_WORDS];

  // One write port, two registered read ports; read data holds when idle
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re0) begin
      rd0 <= mem[req.raddr0];
    end
    if (req.re1) begin
      rd1 <= mem[req.raddr1];
    end
  end

endmodule

FILE: rtl/mtg_seq.sv
module mtg_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_func,
  input  logic [mtg_pkg::WORD_W-1:0]  in_seed_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mtg_pkg::WORD_W-1:0]  out_random_word,
  output mtg_pkg::store_req_t         req,
  input  logic [mtg_pkg::WORD_W-1:0]  rd0,
  input  logic [mtg_pkg::WORD_W-1:0]  rd1
);

  mtg_pkg::state_t state_r, state_nxt;

  logic [mtg_pkg::IDX_W-1:0]  k_r, k_nxt;
  logic [mtg_pkg::WORD_W-1:0] x_r, x_nxt;
  logic [mtg_pkg::WORD_W-1:0] cur_r, cur_nxt;
  logic [mtg_pkg::IDX_W-1:0]  read_idx_r, read_idx_nxt;
  logic [mtg_pkg::IDX_W-1:0]  words_left_r, words_left_nxt;
  logic                       seeded_r, seeded_nxt;
  logic                       draw_pend_r, draw_pend_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [mtg_pkg::WORD_W-1:0] out_word_r, out_word_nxt;

  logic                       in_fire;
  logic [mtg_pkg::IDX_W-1:0]  next_idx;
  logic [mtg_pkg::IDX_W-1:0]  far_idx;
  logic [mtg_pkg::IDX_W-1:0]  draw_idx;
  logic [2*mtg_pkg::WORD_W-1:0] product;

  assign in_ready        = (state_r == mtg_pkg::ST_IDLE);
  assign in_fire         = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

  // Neighbor and far indices of the twist step
  assign next_idx = (k_r == mtg_pkg::LAST_IDX) ? '0 : k_r + 1'b1;
  assign far_idx  = (k_r >= mtg_pkg::FAR_LIMIT) ? k_r - mtg_pkg::FAR_LIMIT
                                                : k_r + mtg_pkg::FAR_OFFSET;
  // Wrap a stray read index back to the start
  assign draw_idx = (read_idx_r > mtg_pkg::LAST_IDX) ? '0 : read_idx_r;

  assign product = x_r * mtg_pkg::SEED_MULT;

  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    x_nxt          = x_r;
    cur_nxt        = cur_r;
    read_idx_nxt   = read_idx_r;
    words_left_nxt = words_left_r;
    seeded_nxt     = seeded_r;
    draw_pend_nxt  = draw_pend_r;
    out_word_nxt   = out_word_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    req            = '0;

    unique case (state_r)
      mtg_pkg::ST_IDLE: begin
        if (in_fire) begin
          priority if (in_func == mtg_pkg::FUNC_SEED) begin
            x_nxt         = in_seed_value | 32'd1;
            k_nxt         = '0;
            draw_pend_nxt = 1'b0;
            state_nxt     = mtg_pkg::ST_SEED;
          end else if (words_left_r == '0) begin
            k_nxt = '0;
            if (!seeded_r) begin
              x_nxt         = mtg_pkg::DEFAULT_SEED | 32'd1;
              draw_pend_nxt = 1'b1;
              state_nxt     = mtg_pkg::ST_SEED;
            end else begin
              state_nxt = mtg_pkg::ST_PRIME;
            end
          end else begin
            // Plain draw: read the word now, deliver it once the output register is free
            req.re0        = 1'b1;
            req.raddr0     = draw_idx;
            read_idx_nxt   = draw_idx + 1'b1;
            words_left_nxt = words_left_r - 1'b1;
            state_nxt      = mtg_pkg::ST_DATA;
          end
        end
      end

      mtg_pkg::ST_SEED: begin
        req.we    = 1'b1;
        req.waddr = k_r;
        req.wdata = x_r;
        x_nxt     = product[mtg_pkg::WORD_W-1:0];
        k_nxt     = k_r + 1'b1;
        if (k_r == mtg_pkg::LAST_IDX) begin
          seeded_nxt     = 1'b1;
          words_left_nxt = '0;
          k_nxt          = '0;
          state_nxt      = draw_pend_r ? mtg_pkg::ST_PRIME : mtg_pkg::ST_IDLE;
        end
      end

      mtg_pkg::ST_PRIME: begin
        req.re0    = 1'b1;
        req.raddr0 = '0;
        state_nxt  = mtg_pkg::ST_REGEN_RD;
      end

      mtg_pkg::ST_REGEN_RD: begin
        // rd0 still holds the old word k
        cur_nxt    = rd0;
        req.re0    = 1'b1;
        req.raddr0 = next_idx;
        req.re1    = 1'b1;
        req.raddr1 = far_idx;
        state_nxt  = mtg_pkg::ST_REGEN_WR;
      end

      mtg_pkg::ST_REGEN_WR: begin
        req.we    = 1'b1;
        req.waddr = k_r;
        req.wdata = mtg_pkg::twist(cur_r, rd0, rd1);
        if (k_r == mtg_pkg::LAST_IDX) begin
          k_nxt          = '0;
          words_left_nxt = mtg_pkg::LAST_IDX;
          read_idx_nxt   = mtg_pkg::IDX_W'(1);
          state_nxt      = mtg_pkg::ST_FETCH;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = mtg_pkg::ST_REGEN_RD;
        end
      end

      mtg_pkg::ST_FETCH: begin
        req.re0    = 1'b1;
        req.raddr0 = '0;
        state_nxt  = mtg_pkg::ST_DATA;
      end

      mtg_pkg::ST_DATA: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_word_nxt  = mtg_pkg::temper(rd0);
          out_valid_nxt = 1'b1;
          state_nxt     = mtg_pkg::ST_IDLE;
        end
      end

      default: state_nxt = mtg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mtg_pkg::ST_IDLE;
      k_r          <= '0;
      read_idx_r   <= '0;
      words_left_r <= '0;
      seeded_r     <= 1'b0;
      draw_pend_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      k_r          <= k_nxt;
      read_idx_r   <= read_idx_nxt;
      words_left_r <= words_left_nxt;
      seeded_r     <= seeded_nxt;
      draw_pend_r  <= draw_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    cur_r      <= cur_nxt;
    out_word_r <= out_word_nxt;
  end

  a_seed_starts_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_func == mtg_pkg::FUNC_SEED) |=> state_r == mtg_pkg::ST_SEED)
    else $error("seed transfer did not start the fill");

  a_empty_draw_refills: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_func == mtg_pkg::FUNC_DRAW) && (words_left_r == '0)
    |=> state_r == mtg_pkg::ST_SEED || state_r == mtg_pkg::ST_PRIME)
    else $error("draw from an empty store did not regenerate");

  a_result_from_data: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == mtg_pkg::ST_DATA)
    else $error("result appeared outside the delivery step");

  a_words_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    words_left_r <= mtg_pkg::LAST_IDX)
    else $error("words left exceeds store size");

endmodule

FILE: rtl/mt19937_random_generator.sv
// MT19937 random word generator, 32-bit, old-style seeding.
// Input channel in_chan carries func and seed_value; func = 1 reseeds the
// 624-word store and gives no result, func = 0 draws one tempered word,
// delivered on out_chan as random_word. Both channels transfer on valid
// and ready high at a rising clock edge.
// Operation: a draw from a filled store does one store read, then loads the
// tempered output register; a new draw is taken only once that word is in
// the output register. When the store is used up, the draw regenerates it
// first with a twist unit that handles each word in a read step (neighbor
// and far word) and then a write-back step. A reseed fills the store
// at one word per cycle through the seed multiplier and keeps the block
// busy until the fill is done; a draw before any seed adds that fill first.
// in_chan.ready is high only while the sequencer is idle.
// Reset (rst_n, synchronous, active low) marks the store unseeded and empty;
// the store itself is not cleared.
// A stalled receiver holds the result in the output register; reseeds and
// one more draw may be taken meanwhile, and that draw's result waits until
// the register frees, with the input held off.
module mt19937_random_generator (
  input  logic      clk,
  input  logic      rst_n,
  mtg_in_if.sink    in_chan,
  mtg_out_if.source out_chan
);

  mtg_pkg::store_req_t         req;
  logic [mtg_pkg::WORD_W-1:0]  rd0;
  logic [mtg_pkg::WORD_W-1:0]  rd1;

  mtg_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_chan.valid),
    .in_ready        (in_chan.ready),
    .in_func         (in_chan.func),
    .in_seed_value   (in_chan.seed_value),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_random_word (out_chan.random_word),
    .req             (req),
    .rd0             (rd0),
    .rd1             (rd1)
  );

  mtg_store u_store (
    .clk (clk),
    .req (req),
    .rd0 (rd0),
    .rd1 (rd1)
  );

endmodule
